### hdl/upd_pkg.sv
// Shared types, constants and helper functions of the URL percent decoder.
package upd_pkg;

  localparam logic [15:0] CapacityReset   = 16'd1024;
  localparam int          QueueDepth      = 2;
  localparam int          MaxResults      = 3;
  localparam int          CfgAddrWidth    = 3;
  localparam logic [7:0]  PctChar         = 8'h25;
  localparam logic [7:0]  HexLetterOffset = 8'h41 - 8'd10;

  // Register indexes of the configuration port.
  typedef enum logic {
    REG_OUT_CAPACITY = 1'b0,
    REG_NONE         = 1'b1
  } reg_index_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_PCT   = 2'd1,
    MODE_DIGIT = 2'd2
  } mode_e;

  // Results caused by one input byte. A count of zero with last set is an end marker.
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [1:0]                 count;
    logic                       last;
    logic                       trunc;
  } bundle_t;

  // Status of the queue as seen by its neighbors.
  typedef struct packed {
    logic not_empty;
    logic full;
  } queue_stat_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] u;
    logic [7:0] r;
    u = (c >= 8'h61) ? (c - 8'h20) : c;
    r = (u >= 8'h41) ? (u - HexLetterOffset) : (u - 8'h30);
    return r[3:0];
  endfunction

endpackage

### hdl/upd_front.sv
// Front end: scans input bytes, tracks escapes and capacity, builds result bundles.
module upd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         in_byte_i,
  input  logic               in_last_i,
  input  logic [15:0]        capacity_i,
  output logic               push_o,
  output upd_pkg::bundle_t   bundle_o
);

  upd_pkg::mode_e mode_q, mode_d;
  logic [7:0]     held_q, held_d;
  logic [15:0]    count_q, count_d;
  logic           ended_q, ended_d;
  logic           dropped_q, dropped_d;

  logic [upd_pkg::MaxResults-1:0][7:0] cand;
  logic [1:0]  ncand;
  logic [1:0]  naccept;
  logic [15:0] room;

  always_comb begin
    upd_pkg::mode_e m;
    logic [7:0]     h;
    logic           c_hex;
    cand    = '0;
    ncand   = 2'd0;
    m       = mode_q;
    h       = held_q;
    ended_d = ended_q;
    c_hex   = upd_pkg::is_hex(in_byte_i);

    if (!ended_q) begin
      if (in_byte_i == 8'h00) begin
        // Terminator flushes whatever escape is pending.
        if (mode_q == upd_pkg::MODE_PCT) begin
          cand[ncand] = upd_pkg::PctChar; ncand = ncand + 2'd1;
        end else if (mode_q == upd_pkg::MODE_DIGIT) begin
          cand[ncand] = upd_pkg::PctChar; ncand = ncand + 2'd1;
          cand[ncand] = held_q;           ncand = ncand + 2'd1;
        end
        m       = upd_pkg::MODE_IDLE;
        h       = 8'h00;
        ended_d = 1'b1;
      end else begin
        if (mode_q == upd_pkg::MODE_PCT && c_hex) begin
          h = in_byte_i;
          m = upd_pkg::MODE_DIGIT;
        end else if (mode_q == upd_pkg::MODE_DIGIT && c_hex) begin
          cand[ncand] = {upd_pkg::hex_val(held_q), upd_pkg::hex_val(in_byte_i)};
          ncand = ncand + 2'd1;
          m = upd_pkg::MODE_IDLE;
          h = 8'h00;
        end else begin
          // A broken escape passes through literally, then the byte is seen afresh.
          if (mode_q == upd_pkg::MODE_PCT) begin
            cand[ncand] = upd_pkg::PctChar; ncand = ncand + 2'd1;
          end else if (mode_q == upd_pkg::MODE_DIGIT) begin
            cand[ncand] = upd_pkg::PctChar; ncand = ncand + 2'd1;
            cand[ncand] = held_q;           ncand = ncand + 2'd1;
            h = 8'h00;
          end
          if (in_byte_i == upd_pkg::PctChar) begin
            m = upd_pkg::MODE_PCT;
          end else begin
            m = upd_pkg::MODE_IDLE;
            cand[ncand] = in_byte_i; ncand = ncand + 2'd1;
          end
        end
        if (in_last_i) begin
          if (m == upd_pkg::MODE_PCT) begin
            cand[ncand] = upd_pkg::PctChar; ncand = ncand + 2'd1;
          end else if (m == upd_pkg::MODE_DIGIT) begin
            cand[ncand] = upd_pkg::PctChar; ncand = ncand + 2'd1;
            cand[ncand] = h;                ncand = ncand + 2'd1;
          end
          m = upd_pkg::MODE_IDLE;
          h = 8'h00;
        end
      end
    end

    // Emits succeed in order while the count stays below capacity minus one.
    room    = ((17'(count_q) + 17'd1) < 17'(capacity_i)) ?
              (capacity_i - count_q - 16'd1) : 16'd0;
    naccept = (room >= 16'(ncand)) ? ncand : room[1:0];
    dropped_d = dropped_q | (naccept != ncand);
    count_d   = count_q + 16'(naccept);
    mode_d    = m;
    held_d    = h;

    bundle_o.bytes = cand;
    bundle_o.count = naccept;
    bundle_o.last  = in_last_i;
    bundle_o.trunc = dropped_d;
    push_o = accept_i && ((naccept != 2'd0) || in_last_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= upd_pkg::MODE_IDLE;
      held_q    <= 8'h00;
      count_q   <= 16'd0;
      ended_q   <= 1'b0;
      dropped_q <= 1'b0;
    end else if (accept_i) begin
      if (in_last_i) begin
        mode_q    <= upd_pkg::MODE_IDLE;
        held_q    <= 8'h00;
        count_q   <= 16'd0;
        ended_q   <= 1'b0;
        dropped_q <= 1'b0;
      end else begin
        mode_q    <= mode_d;
        held_q    <= held_d;
        count_q   <= count_d;
        ended_q   <= ended_d;
        dropped_q <= dropped_d;
      end
    end
  end

endmodule

### hdl/upd_queue.sv
// Short queue of result bundles between the front and back ends.
module upd_queue #(
  parameter int DEPTH = upd_pkg::QueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  upd_pkg::bundle_t     data_i,
  input  logic                 pop_i,
  output upd_pkg::bundle_t     data_o,
  output upd_pkg::queue_stat_t stat_o
);

  localparam int PtrWidth = $clog2(DEPTH);
  localparam int CntWidth = $clog2(DEPTH + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);

  upd_pkg::bundle_t mem_q [DEPTH];
  logic [PtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntWidth-1:0] cnt_q;

  assign data_o           = mem_q[rd_ptr_q];
  assign stat_o.not_empty = (cnt_q != '0);
  assign stat_o.full      = (cnt_q == CntWidth'(DEPTH));

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrWidth'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrWidth'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntWidth'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntWidth'(1);
      end
    end
  end

endmodule

### hdl/upd_back.sv
// Back end: holds one bundle and hands out its results one transfer at a time.
module upd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  upd_pkg::bundle_t     q_data_i,
  input  upd_pkg::queue_stat_t q_stat_i,
  output logic                 pop_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [7:0]           byte_o,
  output logic                 byte_valid_o,
  output logic                 last_o,
  output logic                 trunc_o
);

  upd_pkg::bundle_t cur_q;
  logic             cur_valid_q;
  logic [1:0]       idx_q;
  logic             marker;
  logic             final_elem;
  logic             load;

  assign marker       = (cur_q.count == 2'd0);
  assign final_elem   = marker || (idx_q == (cur_q.count - 2'd1));
  assign valid_o      = cur_valid_q;
  assign byte_o       = marker ? 8'h00 : cur_q.bytes[idx_q];
  assign byte_valid_o = !marker;
  assign last_o       = cur_q.last && final_elem;
  assign trunc_o      = cur_q.trunc;

  assign load  = !cur_valid_q || (ready_i && final_elem);
  assign pop_o = load && q_stat_i.not_empty;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else if (load) begin
      cur_valid_q <= q_stat_i.not_empty;
      idx_q       <= 2'd0;
    end else if (ready_i) begin
      idx_q <= idx_q + 2'd1;
    end
  end

endmodule

### hdl/url_percent_decoder.sv
// Top level of the streaming URL percent decoder with its configuration register.
//
// Source bytes enter on the s_ channel, one byte per transfer, with s_tlast on the
// final byte of a string. A '%' and two hex digits become one byte; broken escapes
// pass through literally. A zero byte ends the string and later bytes are ignored
// until s_tlast. Decoded bytes leave on the m_ channel; m_tuser[0] says the transfer
// carries a byte (0 is an end marker) and m_tuser[1] says bytes were dropped because
// the string reached out_capacity minus one bytes. m_tlast marks the final transfer
// of a string. out_capacity sits at APB address 0.
//
// The front end takes one byte per cycle while s_tready is high and writes its
// results as one bundle into a two-entry queue; the back end drains one result
// per cycle while m_tready is high. Bytes with one result each are sustained at
// one per cycle; a byte with two or three results takes one transfer per result.
// When the receiver stalls, the output holds steady and s_tready drops once the
// queue is full. Reset clears the scanner state and sets out_capacity to 1024.
// The user must write out_capacity only while idle; the block does not enforce it.
module url_percent_decoder #(
  parameter int QUEUE_DEPTH = upd_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic [1:0]  m_tuser,   // [0] out_valid, [1] truncated
  output logic        m_tlast,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [upd_pkg::CfgAddrWidth-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]          capacity_q;
  upd_pkg::reg_index_e  reg_idx;
  logic                 accept;
  logic                 push;
  logic                 pop;
  upd_pkg::bundle_t     push_data;
  upd_pkg::bundle_t     head_data;
  upd_pkg::queue_stat_t q_stat;
  logic                 out_byte_valid;
  logic                 out_trunc;

  // Registers sit on 32-bit words; the word index picks the register.
  assign reg_idx = upd_pkg::reg_index_e'(paddr[upd_pkg::CfgAddrWidth-1]);
  assign pready  = 1'b1;

  always_comb begin
    unique case (reg_idx)
      upd_pkg::REG_OUT_CAPACITY: prdata = {16'h0000, capacity_q};
      default:                   prdata = 32'h0000_0000;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= upd_pkg::CapacityReset;
    end else if (psel && penable && pwrite && pready &&
                 (reg_idx == upd_pkg::REG_OUT_CAPACITY)) begin
      capacity_q <= pwdata[15:0];
    end
  end

  // A byte is taken whenever the queue has room for its bundle.
  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;

  upd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_byte_i  (s_tdata),
    .in_last_i  (s_tlast),
    .capacity_i (capacity_q),
    .push_o     (push),
    .bundle_o   (push_data)
  );

  upd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .pop_i  (pop),
    .data_o (head_data),
    .stat_o (q_stat)
  );

  upd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_data_i     (head_data),
    .q_stat_i     (q_stat),
    .pop_o        (pop),
    .valid_o      (m_tvalid),
    .ready_i      (m_tready),
    .byte_o       (m_tdata),
    .byte_valid_o (out_byte_valid),
    .last_o       (m_tlast),
    .trunc_o      (out_trunc)
  );

  assign m_tuser = {out_trunc, out_byte_valid};

endmodule

### hdl/upd_checker.sv
// Port-level checker for the URL percent decoder and its bind to the top level.
module upd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [upd_pkg::CfgAddrWidth-1:0] paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  // A stalled output transfer keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
    $stable(m_tlast))
  else $error("output changed while stalled");

  // An end marker carries no byte and always closes the string.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata == 8'h00))
  else $error("end marker without last or with data");

  // The capacity register is 16 bits wide.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !paddr[upd_pkg::CfgAddrWidth-1] |-> (prdata[31:16] == 16'h0000))
  else $error("capacity readback has upper bits set");

  // A capacity write reads back on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && !paddr[upd_pkg::CfgAddrWidth-1] |=>
    paddr[upd_pkg::CfgAddrWidth-1] || (prdata[15:0] == $past(pwdata[15:0])))
  else $error("capacity write not reflected");

endmodule

bind url_percent_decoder upd_checker u_upd_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .paddr    (paddr),
  .pwdata   (pwdata),
  .prdata   (prdata)
);

### tb/testbench.sv
// Self-checking testbench of the URL percent decoder with stream stimulus and APB register writes.
module testbench;
  import upd_pkg::*;

  // One result transfer as it appears on the output stream.
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       trunc;
  } dec_result_t;

  // One row of the directed table. Rows marked typed carry their single expected result;
  // all others are checked against the decoding predictor.
  typedef struct packed {
    logic [7:0]  in_byte;
    logic        in_last;
    logic        typed;
    dec_result_t want;
  } dir_row_t;

  // Receiver stall patterns, picked at random.
  typedef enum int {
    RX_OPEN,
    RX_THIRDS,
    RX_COIN,
    RX_STALLS
  } rx_pattern_e;

  localparam int CycleLimit   = 200000;
  localparam int PhaseItems   = 38;
  localparam int NumPhases    = 7;
  localparam int SettleCycles = 8;
  localparam int RxPeriod     = 150;
  localparam logic [CfgAddrWidth-1:0] CapAddr  = CfgAddrWidth'(4 * int'(REG_OUT_CAPACITY));
  localparam logic [CfgAddrWidth-1:0] NoneAddr = CfgAddrWidth'(4 * int'(REG_NONE));
  localparam dec_result_t Untyped = '0;
  localparam int NumRows = 21;

  localparam dir_row_t DirRows [NumRows] = '{
    '{"A",   1'b0, 1'b1, '{"A", 1'b1, 1'b0, 1'b0}},
    // Mixed case escape decodes to the top byte value.
    '{"%",   1'b0, 1'b0, Untyped},
    '{"f",   1'b0, 1'b0, Untyped},
    '{"F",   1'b0, 1'b0, Untyped},
    // An escape that decodes to a zero byte is data, not a terminator.
    '{"%",   1'b0, 1'b0, Untyped},
    '{"0",   1'b0, 1'b0, Untyped},
    '{"0",   1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
    // A non-hex byte right after the percent sign.
    '{"%",   1'b0, 1'b0, Untyped},
    '{"G",   1'b0, 1'b0, Untyped},
    // A non-hex byte after one held digit gives three results.
    '{"%",   1'b0, 1'b0, Untyped},
    '{"4",   1'b0, 1'b0, Untyped},
    '{"z",   1'b0, 1'b0, Untyped},
    // A percent sign on the last byte breaks the held escape and is then flushed
    // itself, which fills all three result slots of the step.
    '{"%",   1'b0, 1'b0, Untyped},
    '{"a",   1'b0, 1'b0, Untyped},
    '{"%",   1'b1, 1'b0, Untyped},
    // A lone terminator on the last byte gives only the end marker.
    '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
    // The terminator flushes the pending percent sign; later bytes are ignored.
    '{"%",   1'b0, 1'b0, Untyped},
    '{8'h00, 1'b0, 1'b0, Untyped},
    '{8'hFF, 1'b0, 1'b0, Untyped},
    '{"q",   1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
    '{8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0}}
  };

  logic        clk_i;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [CfgAddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata   = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  url_percent_decoder DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Decoder state as the predictor sees it.
  logic [15:0] cap_q     = CapacityReset;
  mode_e       scan_q    = MODE_IDLE;
  logic [7:0]  held_q    = 8'h00;
  logic [15:0] wr_cnt_q  = 16'h0;
  logic        ended_q   = 1'b0;
  logic        dropped_q = 1'b0;

  // Results of the byte just decoded.
  logic [7:0]  step_bytes [MaxResults];
  int          step_n;
  dec_result_t step_res [MaxResults];
  int          res_n;

  dec_result_t out_expected [$];
  logic [7:0]  text_q [$];
  int          fails      = 0;
  int          cycle_cnt  = 0;
  int          burst_left = 0;

  function automatic logic hex_digit(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    if (c <= "9") begin
      v = c - "0";
    end else begin
      v = (c | 8'h20) - "a" + 8'd10;
    end
    return v[3:0];
  endfunction

  function automatic logic [7:0] rand_hex();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'("0" + v);
    if ($urandom_range(0, 1) == 1) return 8'("A" + v - 10);
    return 8'("a" + v - 10);
  endfunction

  function automatic logic [7:0] rand_nonhex();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (hex_digit(c));
    return c;
  endfunction

  // A byte is written only while the string has room for it, and at most three per step.
  task automatic emit_byte(input logic [7:0] b);
    if ((17'(wr_cnt_q) + 17'd1) < 17'(cap_q) && step_n < MaxResults) begin
      step_bytes[step_n] = b;
      step_n++;
      wr_cnt_q = wr_cnt_q + 16'd1;
    end else begin
      dropped_q = 1'b1;
    end
  endtask

  task automatic literal_byte(input logic [7:0] c);
    if (c == PctChar) begin
      scan_q = MODE_PCT;
    end else begin
      emit_byte(c);
    end
  endtask

  task automatic scan_byte(input logic [7:0] c);
    case (scan_q)
      MODE_PCT: begin
        if (hex_digit(c)) begin
          held_q = c;
          scan_q = MODE_DIGIT;
        end else begin
          emit_byte(PctChar);
          scan_q = MODE_IDLE;
          literal_byte(c);
        end
      end
      MODE_DIGIT: begin
        if (hex_digit(c)) begin
          emit_byte({digit_value(held_q), digit_value(c)});
          scan_q = MODE_IDLE;
          held_q = 8'h00;
        end else begin
          emit_byte(PctChar);
          emit_byte(held_q);
          scan_q = MODE_IDLE;
          held_q = 8'h00;
          literal_byte(c);
        end
      end
      default: begin
        scan_q = MODE_IDLE;
        literal_byte(c);
      end
    endcase
  endtask

  // A pending escape at the end of a string goes out as literal bytes.
  task automatic flush_escape();
    if (scan_q == MODE_PCT) begin
      emit_byte(PctChar);
    end else if (scan_q == MODE_DIGIT) begin
      emit_byte(PctChar);
      emit_byte(held_q);
    end
    scan_q = MODE_IDLE;
    held_q = 8'h00;
  endtask

  // Decodes one accepted input byte into step_res[0 .. res_n-1].
  task automatic decode_step(input logic [7:0] c, input logic l);
    step_n = 0;
    if (!ended_q) begin
      if (c == 8'h00) begin
        flush_escape();
        ended_q = 1'b1;
      end else begin
        scan_byte(c);
        if (l) flush_escape();
      end
    end
    res_n = step_n;
    for (int k = 0; k < step_n; k++) begin
      step_res[k] = '{step_bytes[k], 1'b1, l && (k == step_n - 1), dropped_q};
    end
    if (l) begin
      if (res_n == 0) begin
        step_res[0] = '{8'h00, 1'b0, 1'b1, dropped_q};
        res_n = 1;
      end
      scan_q    = MODE_IDLE;
      held_q    = 8'h00;
      wr_cnt_q  = 16'h0;
      ended_q   = 1'b0;
      dropped_q = 1'b0;
    end
  endtask

  task automatic push_results();
    for (int k = 0; k < res_n; k++) out_expected.push_back(step_res[k]);
  endtask

  // Offers one byte and returns at the edge where the transfer takes place. The sender
  // works in bursts with idle gaps between them.
  task automatic send_item(input logic [7:0] b, input logic l);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= l;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  // Bytes after a terminator give no result, so the bench also lets the decoder settle
  // once the last expected transfer has come.
  task automatic drain_and_settle();
    s_tvalid <= 1'b0;
    while (out_expected.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [CfgAddrWidth-1:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == CapAddr) cap_q = data[15:0];
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_capacity();
    logic [31:0] rd;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CapAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== {16'h0, cap_q}) begin
      $error("out_capacity: expected %0d, actual %0d", cap_q, rd);
      fails++;
    end
  endtask

  // Mostly well-formed strings: plain characters and valid escapes, with broken escapes,
  // terminators and arbitrary bytes mixed in.
  task automatic build_string();
    int tokens;
    int roll;
    text_q.delete();
    tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 7);
    for (int t = 0; t < tokens; t++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        text_q.push_back(8'($urandom_range(32, 126)));
      end else if (roll < 65) begin
        text_q.push_back(PctChar);
        text_q.push_back(rand_hex());
        text_q.push_back(rand_hex());
      end else if (roll < 75) begin
        text_q.push_back(PctChar);
        if ($urandom_range(0, 1) == 1) text_q.push_back(rand_hex());
        text_q.push_back(rand_nonhex());
      end else if (roll < 80) begin
        text_q.push_back(8'h00);
      end else if (roll < 88) begin
        text_q.push_back(PctChar);
      end else begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // The receiver switches between stall patterns at random.
  rx_pattern_e rx_mode  = RX_OPEN;
  int          rx_cycle = 0;
  int          rx_stall = 0;

  always @(posedge clk_i) begin
    if (rx_cycle % RxPeriod == 0) rx_mode = rx_pattern_e'($urandom_range(0, 3));
    rx_cycle++;
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_THIRDS: m_tready <= (rx_cycle % 3 == 0);
      RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
      default: begin
        if (rx_stall > 0) begin
          rx_stall--;
          m_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          rx_stall = $urandom_range(1, 20);
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    endcase
  end

  // Each output transfer is matched against the oldest expected result.
  always @(posedge clk_i) begin : out_check
    dec_result_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (out_expected.size() == 0) begin
        $error("unexpected transfer: out_byte %h, out_valid %b, out_last %b",
               m_tdata, m_tuser[0], m_tlast);
        fails++;
      end else begin
        want = out_expected.pop_front();
        if (m_tdata !== want.data) begin
          $error("out_byte: expected %h, actual %h", want.data, m_tdata);
          fails++;
        end
        if (m_tuser[0] !== want.valid) begin
          $error("out_valid: expected %b, actual %b", want.valid, m_tuser[0]);
          fails++;
        end
        if (m_tlast !== want.last) begin
          $error("out_last: expected %b, actual %b", want.last, m_tlast);
          fails++;
        end
        if (m_tuser[1] !== want.trunc) begin
          $error("truncated: expected %b, actual %b", want.trunc, m_tuser[1]);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0] caps [NumPhases];
    int          sent;
    logic        l;
    caps[0] = 16'hFFFF;
    caps[1] = 16'd1;
    caps[2] = 16'd2;
    caps[3] = 16'd4;
    caps[4] = 16'($urandom_range(3, 30));
    caps[5] = 16'($urandom_range(1, 65535));
    caps[6] = 16'($urandom_range(5, 12));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    check_capacity();

    for (int r = 0; r < NumRows; r++) begin
      send_item(DirRows[r].in_byte, DirRows[r].in_last);
      decode_step(DirRows[r].in_byte, DirRows[r].in_last);
      if (DirRows[r].typed) begin
        out_expected.push_back(DirRows[r].want);
      end else begin
        push_results();
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      drain_and_settle();
      // A write to the unused address must leave the capacity alone.
      if (p == 3) apb_write(NoneAddr, 32'h0000_0003);
      apb_write(CapAddr, {16'h0, caps[p]});
      check_capacity();
      sent = 0;
      while (sent < PhaseItems) begin
        build_string();
        for (int i = 0; i < text_q.size(); i++) begin
          l = (i == text_q.size() - 1);
          send_item(text_q[i], l);
          decode_step(text_q[i], l);
          push_results();
          sent++;
        end
      end
    end

    drain_and_settle();
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hdl/upd_pkg.sv
hdl/upd_front.sv
hdl/upd_queue.sv
hdl/upd_back.sv
hdl/url_percent_decoder.sv
hdl/upd_checker.sv
tb/testbench.sv
